// ===== rtl/core/dht_single_wire_reader_macros.svh =====
// assertion macros shared by the reader's checker
`ifndef DHT_SINGLE_WIRE_READER_MACROS_SVH
`define DHT_SINGLE_WIRE_READER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DHTR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DHTR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dhtr_pkg.sv =====
// types, constants and helpers of the single-wire sensor reader
package dhtr_pkg;

   localparam int FRAME_BYTES = 5;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int BIT_IDX_W   = 6;
   localparam int ELAPSED_W   = 20;
   localparam int TICKS_W     = 16;
   localparam int HUND_W      = 15;

   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   // phase codes
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_START     = 3'd1;
   localparam logic [2:0] PH_WAIT_LOW  = 3'd2;
   localparam logic [2:0] PH_RESP_LOW  = 3'd3;
   localparam logic [2:0] PH_RESP_HIGH = 3'd4;
   localparam logic [2:0] PH_BIT_LOW   = 3'd5;
   localparam logic [2:0] PH_BIT_HIGH  = 3'd6;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TIMEOUT  = 2'd1;
   localparam logic [1:0] ST_CHECKSUM = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THR   = 2'd2;

   localparam logic [ELAPSED_W-1:0] START_LOW_RST = 20'd18000;
   localparam logic [TICKS_W-1:0]   TIMEOUT_RST   = 16'd200;
   localparam logic [TICKS_W-1:0]   ONE_THR_RST   = 16'd50;

   typedef struct packed {
      logic [2:0]            phase;
      logic [ELAPSED_W-1:0]  elapsed;
      logic [BIT_IDX_W-1:0]  bit_index;
      logic [FRAME_BITS-1:0] frame_bits;
   } state_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] start_low_ticks;
      logic [TICKS_W-1:0]   timeout_ticks;
      logic [TICKS_W-1:0]   one_threshold_ticks;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
   } flags_type;

   // integer byte * 100 + fraction byte, at most 25755
   function automatic logic [HUND_W-1:0] hundredths(input logic [7:0] int_byte,
                                                    input logic [7:0] frac_byte);
      hundredths = HUND_W'(int_byte) * HUND_W'(100) + HUND_W'(frac_byte);
   endfunction

   // byte k of the frame, first received byte is k = 0
   function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] frame,
                                             input int k);
      frame_byte = frame[FRAME_BITS-1-8*k -: 8];
   endfunction

endpackage

// ===== rtl/core/dhtr_step.sv =====
// next-state and result logic for one sampling tick
module dhtr_step (
   input  dhtr_pkg::state_type                cur,
   input  dhtr_pkg::cfg_type                  cfg,
   input  logic [dhtr_pkg::HUND_W-1:0]        hum_cur,
   input  logic [dhtr_pkg::HUND_W-1:0]        temp_cur,
   input  logic                               start_req,
   input  logic                               line_level,
   output dhtr_pkg::state_type                nxt,
   output logic [dhtr_pkg::HUND_W-1:0]        hum_nxt,
   output logic [dhtr_pkg::HUND_W-1:0]        temp_nxt,
   output dhtr_pkg::flags_type                flags
);
   import dhtr_pkg::*;

   logic [ELAPSED_W-1:0]  elapsed_inc;
   logic [BIT_IDX_W-1:0]  bit_idx_inc;
   logic                  bit_val;
   logic                  waited;
   logic [FRAME_BITS-1:0] shifted;
   logic [7:0]            sum;
   logic                  sum_ok;

   assign elapsed_inc = (cur.elapsed < ELAPSED_MAX) ? cur.elapsed + 1'b1 : cur.elapsed;
   assign bit_idx_inc = cur.bit_index + 1'b1;
   assign bit_val     = cur.elapsed >= ELAPSED_W'(cfg.one_threshold_ticks);
   assign shifted     = {cur.frame_bits[FRAME_BITS-2:0], bit_val};
   assign waited      = (cur.phase == PH_WAIT_LOW) || (cur.phase == PH_RESP_HIGH) ||
                        (cur.phase == PH_BIT_HIGH);

   always_comb begin
      sum = '0;
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
         sum = sum + frame_byte(shifted, k);
      end
   end
   assign sum_ok = (sum == frame_byte(shifted, FRAME_BYTES - 1));

   always_comb begin
      nxt      = cur;
      hum_nxt  = hum_cur;
      temp_nxt = temp_cur;
      flags    = '0;
      unique case (cur.phase) inside
         PH_IDLE: begin
            if (start_req) begin
               flags.drive_low = 1'b1;
               nxt.frame_bits  = '0;
               nxt.bit_index   = '0;
               if (cfg.start_low_ticks <= ELAPSED_W'(1)) begin
                  nxt.phase   = PH_WAIT_LOW;
                  nxt.elapsed = '0;
               end else begin
                  nxt.phase   = PH_START;
                  nxt.elapsed = ELAPSED_W'(1);
               end
            end
         end
         PH_START: begin
            flags.drive_low = 1'b1;
            if (elapsed_inc >= cfg.start_low_ticks) begin
               nxt.phase   = PH_WAIT_LOW;
               nxt.elapsed = '0;
            end else begin
               nxt.elapsed = elapsed_inc;
            end
         end
         PH_WAIT_LOW, PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
            if (line_level == waited) begin
               nxt.elapsed = elapsed_inc;
               if (elapsed_inc >= ELAPSED_W'(cfg.timeout_ticks)) begin
                  nxt.phase      = PH_IDLE;
                  nxt.elapsed    = '0;
                  flags.done_res = 1'b1;
                  flags.status   = ST_TIMEOUT;
               end
            end else if (cur.phase == PH_BIT_HIGH) begin
               // falling edge closes a data bit
               nxt.frame_bits = shifted;
               nxt.bit_index  = bit_idx_inc;
               nxt.elapsed    = ELAPSED_W'(1);
               if (bit_idx_inc >= BIT_IDX_W'(FRAME_BITS)) begin
                  nxt.phase      = PH_IDLE;
                  nxt.elapsed    = '0;
                  flags.done_res = 1'b1;
                  if (sum_ok) begin
                     hum_nxt      = hundredths(frame_byte(shifted, 0), frame_byte(shifted, 1));
                     temp_nxt     = hundredths(frame_byte(shifted, 2), frame_byte(shifted, 3));
                     flags.status = ST_OK;
                  end else begin
                     flags.status = ST_CHECKSUM;
                  end
               end else begin
                  nxt.phase = PH_BIT_LOW;
               end
            end else begin
               nxt.elapsed = ELAPSED_W'(1);
               if (cur.phase == PH_BIT_LOW) begin
                  nxt.phase = PH_BIT_HIGH;
               end else if (cur.phase == PH_RESP_HIGH) begin
                  nxt.phase = PH_BIT_LOW;
               end else begin
                  nxt.phase = cur.phase + 3'd1;
               end
            end
         end
         default: begin
            nxt.phase   = PH_IDLE;
            nxt.elapsed = '0;
         end
      endcase
      flags.busy_res = (nxt.phase != PH_IDLE);
   end

endmodule

// ===== rtl/core/dht_single_wire_reader.sv =====
// single-wire humidity/temperature sensor reader, one word per microsecond tick
//
//   port group | dir  | word contents
//   req_*      | in   | one sampling tick: start request and wire level
//   rsp_*      | out  | one result per tick: drive, busy, status, readings; tlast = done
//   csr_*      | in   | register writes: start low ticks, timeout, one threshold
//
// a tick is registered on accept, then evaluated into the result register, so one word
// per cycle is sustained while rsp_tready stays high.
// a result stalled on rsp_tready holds; one more tick is held in the input register.
// reset is synchronous and clears control state and sets the config registers to defaults.
module dht_single_wire_reader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dhtr_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] start_req, [1] line_level
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] drive_low, [1] busy_res, [3:2] status, [18:4] humidity_hundredths,
   // [33:19] temperature_hundredths
   output logic [dhtr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,  // done_res
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dhtr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dhtr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import dhtr_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_start_ff, in_level_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_last_ff;
   logic                  advance;

   state_type             state_ff, state_in;
   logic [HUND_W-1:0]     hum_ff, hum_in, temp_ff, temp_in;
   cfg_type               cfg_ff;
   flags_type             flags;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   dhtr_step u_step (
      .cur        (state_ff),
      .cfg        (cfg_ff),
      .hum_cur    (hum_ff),
      .temp_cur   (temp_ff),
      .start_req  (in_start_ff),
      .line_level (in_level_ff),
      .nxt        (state_in),
      .hum_nxt    (hum_in),
      .temp_nxt   (temp_in),
      .flags      (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         hum_ff       <= '0;
         temp_ff      <= '0;
         cfg_ff.start_low_ticks     <= START_LOW_RST;
         cfg_ff.timeout_ticks       <= TIMEOUT_RST;
         cfg_ff.one_threshold_ticks <= ONE_THR_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
            hum_ff   <= hum_in;
            temp_ff  <= temp_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_START_LOW: cfg_ff.start_low_ticks     <= csr_data;
               CSR_TIMEOUT:   cfg_ff.timeout_ticks       <= csr_data[TICKS_W-1:0];
               CSR_ONE_THR:   cfg_ff.one_threshold_ticks <= csr_data[TICKS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_start_ff <= req_tdata[0];
         in_level_ff <= req_tdata[1];
      end
      if (advance) begin
         out_data_ff <= {(RSP_DATA_W - 4 - 2 * HUND_W)'(0), temp_in, hum_in, flags.status,
                         flags.busy_res, flags.drive_low};
         out_last_ff <= flags.done_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/core/dhtr_checker.sv =====
// port-level checks of the sensor reader and their binding
`include "dht_single_wire_reader_macros.svh"

module dhtr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dhtr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import dhtr_pkg::*;

   `DHTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result word changed")
   `DHTR_ASSERT_NOW(a_done_idle, clock, reset, rsp_tvalid && rsp_tlast,
      !rsp_tdata[1], "reading ended but still busy")
   `DHTR_ASSERT_NOW(a_status_done, clock, reset, rsp_tvalid && !rsp_tlast,
      rsp_tdata[3:2] == ST_OK, "status set without done")
   `DHTR_ASSERT_NOW(a_drive_busy, clock, reset, rsp_tvalid && rsp_tdata[0],
      rsp_tdata[1] && !rsp_tlast, "line driven outside a reading")

endmodule

bind dht_single_wire_reader dhtr_checker u_dhtr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
